// ===== design/hcd_pkg.sv =====
// Types, constants and helper functions shared by the chunked transfer decoder.
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

    localparam int CHUNK_SIZE_WIDTH = 24;
    localparam int COUNT_WIDTH      = 16;
    localparam int BYTE_WIDTH       = 8;
    localparam int LENGTH_WIDTH     = 16;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_HIGH_A = 8'h41;
    localparam logic [7:0] CHAR_HIGH_F = 8'h46;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_SIZE    = 4'd1,
        PH_EXT     = 4'd2,
        PH_SIZE_LF = 4'd3,
        PH_DATA    = 4'd4,
        PH_DATA_CR = 4'd5,
        PH_DATA_LF = 4'd6,
        PH_LAST_CR = 4'd7,
        PH_LAST_LF = 4'd8,
        PH_DONE    = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_MALFORMED  = 2'd3
    } t_status;

    typedef struct packed {
        logic                    produce;
        logic                    has_byte;
        t_status                 status;
        logic [BYTE_WIDTH-1:0]   out_byte;
        logic [LENGTH_WIDTH-1:0] total_length;
    } t_result;

    // Returns the digit value in the low four bits and a valid flag in the top bit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            d = c - CHAR_LOW_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_HIGH_A && c <= CHAR_HIGH_F) begin
            d = c - CHAR_HIGH_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

// ===== design/hcd_parser.sv =====
// Framing state machine: header skip, chunk-size parsing, data pass-through and trailer checks.
`timescale 1ns / 1ps
`default_nettype none

module hcd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eob,
    output hcd_pkg::t_result     o_result
);

    localparam int SW = hcd_pkg::CHUNK_SIZE_WIDTH;
    localparam int CW = hcd_pkg::COUNT_WIDTH;

    hcd_pkg::t_phase  r_phase, n_phase;
    logic [1:0]       r_match, n_match;
    logic [SW-1:0]    r_remaining, n_remaining;
    logic [CW-1:0]    r_count, n_count;

    logic [4:0]       w_hex;
    logic [7:0]       w_pat;
    logic [SW-1:0]    w_rem_dec;
    logic             w_has;
    hcd_pkg::t_status w_status;

    assign w_hex     = hcd_pkg::hex_value(i_byte);
    assign w_rem_dec = r_remaining - SW'(1);
    assign w_pat     = r_match[0] ? hcd_pkg::CHAR_LF : hcd_pkg::CHAR_CR;

    // Next state.
    always_comb begin
        n_phase     = r_phase;
        n_match     = r_match;
        n_remaining = r_remaining;
        n_count     = r_count;
        case (r_phase)
            hcd_pkg::PH_HEADER: begin
                if (i_byte == w_pat) begin
                    if (r_match == 2'd3) begin
                        n_match     = 2'd0;
                        n_remaining = '0;
                        n_phase     = hcd_pkg::PH_SIZE;
                    end else begin
                        n_match = r_match + 2'd1;
                    end
                end else begin
                    n_match = (i_byte == hcd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            hcd_pkg::PH_SIZE: begin
                if (w_hex[4]) begin
                    if (r_remaining[SW-1 -: 4] != 4'd0) begin
                        n_remaining = '1;
                    end else begin
                        n_remaining = {r_remaining[SW-5:0], w_hex[3:0]};
                    end
                end else begin
                    n_phase = (i_byte == hcd_pkg::CHAR_CR) ? hcd_pkg::PH_SIZE_LF
                                                           : hcd_pkg::PH_EXT;
                end
            end
            hcd_pkg::PH_EXT: begin
                if (i_byte == hcd_pkg::CHAR_CR) begin
                    n_phase = hcd_pkg::PH_SIZE_LF;
                end
            end
            hcd_pkg::PH_SIZE_LF: begin
                if (i_byte == hcd_pkg::CHAR_LF) begin
                    n_phase = (r_remaining == '0) ? hcd_pkg::PH_LAST_CR : hcd_pkg::PH_DATA;
                end else if (i_byte != hcd_pkg::CHAR_CR) begin
                    n_phase = hcd_pkg::PH_EXT;
                end
            end
            hcd_pkg::PH_DATA: begin
                if (r_count != '1) begin
                    n_count = r_count + CW'(1);
                end
                n_remaining = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_phase = hcd_pkg::PH_DATA_CR;
                end
            end
            hcd_pkg::PH_DATA_CR: begin
                n_phase = (i_byte == hcd_pkg::CHAR_CR) ? hcd_pkg::PH_DATA_LF : hcd_pkg::PH_DONE;
            end
            hcd_pkg::PH_LAST_CR: begin
                n_phase = (i_byte == hcd_pkg::CHAR_CR) ? hcd_pkg::PH_LAST_LF : hcd_pkg::PH_DONE;
            end
            hcd_pkg::PH_DATA_LF: begin
                if (i_byte == hcd_pkg::CHAR_LF) begin
                    n_remaining = '0;
                    n_phase     = hcd_pkg::PH_SIZE;
                end else begin
                    n_phase = hcd_pkg::PH_DONE;
                end
            end
            hcd_pkg::PH_LAST_LF: begin
                n_phase = hcd_pkg::PH_DONE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        w_has    = 1'b0;
        w_status = hcd_pkg::ST_NONE;
        case (r_phase)
            hcd_pkg::PH_DATA: begin
                w_has = 1'b1;
            end
            hcd_pkg::PH_DATA_CR, hcd_pkg::PH_LAST_CR: begin
                if (i_byte != hcd_pkg::CHAR_CR) begin
                    w_status = hcd_pkg::ST_MALFORMED;
                end
            end
            hcd_pkg::PH_DATA_LF: begin
                if (i_byte != hcd_pkg::CHAR_LF) begin
                    w_status = hcd_pkg::ST_MALFORMED;
                end
            end
            hcd_pkg::PH_LAST_LF: begin
                w_status = (i_byte == hcd_pkg::CHAR_LF) ? hcd_pkg::ST_COMPLETE
                                                        : hcd_pkg::ST_MALFORMED;
            end
            default: begin
                w_status = hcd_pkg::ST_NONE;
            end
        endcase
        if (i_eob && r_phase != hcd_pkg::PH_DONE && w_status == hcd_pkg::ST_NONE) begin
            w_status = hcd_pkg::ST_INCOMPLETE;
        end
    end

    always_comb begin
        o_result.produce  = w_has || (w_status != hcd_pkg::ST_NONE);
        o_result.has_byte = w_has;
        o_result.status   = w_status;
        o_result.out_byte = w_has ? i_byte : 8'd0;
        if (33'(n_count) > 33'({hcd_pkg::LENGTH_WIDTH{1'b1}})) begin
            o_result.total_length = '1;
        end else begin
            o_result.total_length = hcd_pkg::LENGTH_WIDTH'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hcd_pkg::PH_HEADER;
            r_match     <= 2'd0;
            r_remaining <= '0;
            r_count     <= '0;
        end else if (i_en) begin
            if (i_eob) begin
                r_phase     <= hcd_pkg::PH_HEADER;
                r_match     <= 2'd0;
                r_remaining <= '0;
                r_count     <= '0;
            end else begin
                r_phase     <= n_phase;
                r_match     <= n_match;
                r_remaining <= n_remaining;
                r_count     <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/http_chunked_decoder.sv =====
// Top level of the HTTP/1.1 chunked transfer decoder with input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a chunked HTTP response one byte per request and accepts a new byte in
// every cycle while results are taken. Each byte is held in an input register,
// run through the framing state machine, and any result lands in an output
// register, so a byte passes through both registers before it appears at the
// output. Bytes that give no result (header, size lines, ignored tail) are
// consumed even while the output is stalled. The end-of-buffer byte rearms the
// decoder for a new response.
module http_chunked_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] byte_in
    input  wire logic        i_s_tlast,   // end_of_buffer
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [7:0] out_byte, [23:8] total_length
    output logic [2:0]       o_m_tuser    // [0] has_byte, [2:1] status
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eob;
    logic             r_out_valid;
    hcd_pkg::t_result r_out;

    hcd_pkg::t_result w_result;
    logic             w_out_free;
    logic             w_process;

    hcd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_process),
        .i_byte   (r_in_byte),
        .i_eob    (r_in_eob),
        .o_result (w_result)
    );

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_process  = r_in_valid && (w_out_free || !w_result.produce);
    assign o_s_tready = !r_in_valid || w_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_eob  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_process && w_result.produce) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process && w_result.produce) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.total_length, r_out.out_byte};
    assign o_m_tuser  = {r_out.status, r_out.has_byte};

endmodule

`default_nettype wire

// ===== tb/http_chunked_decoder_checker.sv =====
// Checker for the chunked transfer decoder: predicts each result and compares it field by field.
`timescale 1ns / 1ps

module http_chunked_decoder_checker
    import hcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_in
    input  logic        i_s_tlast,   // end_of_buffer
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] out_byte, [23:8] total_length
    input  logic [2:0]  i_m_tuser,   // [0] has_byte, [2:1] status
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam int PRINT_CAP = 40;

    typedef struct {
        logic [7:0]  out_byte;
        logic        has_byte;
        t_status     status;
        logic [15:0] total_length;
    } decoded_result_t;

    decoded_result_t decoded_q[$];

    t_phase      phase_q;
    logic [1:0]  crlf_seen;
    logic [23:0] size_left;
    logic [15:0] payload_total;
    int          mismatch_total;

    initial begin
        mismatch_total = 0;
    end

    function automatic void rearm_decoder();
        phase_q       = PH_HEADER;
        crlf_seen     = 2'd0;
        size_left     = 24'd0;
        payload_total = 16'd0;
    endfunction

    // The top bit flags a hexadecimal digit; the low nibble holds its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c inside {[CHAR_ZERO:CHAR_NINE]})
            return {1'b1, c[3:0]};
        if (c inside {[CHAR_LOW_A:CHAR_LOW_F], [CHAR_HIGH_A:CHAR_HIGH_F]})
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic bit decode_byte(input logic [7:0] c, input logic eob,
                                       output decoded_result_t res);
        logic        has;
        t_status     st;
        logic        was_done;
        logic [4:0]  digit;
        logic [27:0] grown;
        has      = 1'b0;
        st       = ST_NONE;
        was_done = (phase_q == PH_DONE);
        case (phase_q)
            PH_HEADER: begin
                if (c == (crlf_seen[0] ? CHAR_LF : CHAR_CR)) begin
                    if (crlf_seen == 2'd3) begin
                        crlf_seen = 2'd0;
                        size_left = 24'd0;
                        phase_q   = PH_SIZE;
                    end else begin
                        crlf_seen = crlf_seen + 2'd1;
                    end
                end else begin
                    crlf_seen = (c == CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_SIZE: begin
                digit = hex_digit(c);
                if (digit[4]) begin
                    grown     = {size_left, digit[3:0]};
                    size_left = (grown > 28'hFFFFFF) ? 24'hFFFFFF : grown[23:0];
                end else begin
                    phase_q = (c == CHAR_CR) ? PH_SIZE_LF : PH_EXT;
                end
            end
            PH_EXT: begin
                if (c == CHAR_CR) phase_q = PH_SIZE_LF;
            end
            PH_SIZE_LF: begin
                if (c == CHAR_LF) phase_q = (size_left == 24'd0) ? PH_LAST_CR : PH_DATA;
                else if (c != CHAR_CR) phase_q = PH_EXT;
            end
            PH_DATA: begin
                has = 1'b1;
                if (payload_total != 16'hFFFF) payload_total = payload_total + 16'd1;
                size_left = size_left - 24'd1;
                if (size_left == 24'd0) phase_q = PH_DATA_CR;
            end
            PH_DATA_CR, PH_LAST_CR: begin
                if (c == CHAR_CR) begin
                    phase_q = (phase_q == PH_DATA_CR) ? PH_DATA_LF : PH_LAST_LF;
                end else begin
                    st      = ST_MALFORMED;
                    phase_q = PH_DONE;
                end
            end
            PH_DATA_LF: begin
                if (c == CHAR_LF) begin
                    size_left = 24'd0;
                    phase_q   = PH_SIZE;
                end else begin
                    st      = ST_MALFORMED;
                    phase_q = PH_DONE;
                end
            end
            PH_LAST_LF: begin
                st      = (c == CHAR_LF) ? ST_COMPLETE : ST_MALFORMED;
                phase_q = PH_DONE;
            end
            default: ;
        endcase
        if (eob && !was_done && st == ST_NONE) st = ST_INCOMPLETE;
        res.out_byte     = has ? c : 8'd0;
        res.has_byte     = has;
        res.status       = st;
        res.total_length = payload_total;
        if (eob) rearm_decoder();
        return has || (st != ST_NONE);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_total < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        decoded_result_t want;
        decoded_result_t fresh;
        if (!i_rst_n) begin
            rearm_decoder();
            decoded_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata=%06h tuser=%01h",
                                              i_m_tdata, i_m_tuser));
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_tdata[7:0] !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_m_tdata[7:0], want.out_byte));
                    if (i_m_tuser[0] !== want.has_byte)
                        report_mismatch($sformatf("has_byte %b, expected %b",
                                                  i_m_tuser[0], want.has_byte));
                    if (i_m_tuser[2:1] !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  i_m_tuser[2:1], want.status.name()));
                    if (i_m_tdata[23:8] !== want.total_length)
                        report_mismatch($sformatf("total_length %0d, expected %0d",
                                                  i_m_tdata[23:8], want.total_length));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (decode_byte(i_s_tdata, i_s_tlast, fresh)) decoded_q.push_back(fresh);
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= decoded_q.size();
    end

endmodule

// ===== tb/tb_http_chunked_decoder.sv =====
// Testbench top for the chunked transfer decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_http_chunked_decoder;
    import hcd_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int DRAIN_CYCLES    = 20;

    typedef logic [7:0] byte_q_t[$];

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire  [2:0]  m_tuser;

    int mismatches;
    int outstanding;
    int tx_idle_pct  = 19;
    int rx_idle_pct  = 46;
    int bytes_sent   = 0;
    int idle_cycles  = 0;
    bit hold_request = 1'b0;

    always #10 i_clk = ~i_clk;

    http_chunked_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    http_chunked_decoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // The long hold-off lets the decoder fill up and stall its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb_http_chunked_decoder: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0:       return CHAR_CR;
            1:       return CHAR_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_crlf(ref byte_q_t q, input bit may_break);
        if (may_break && $urandom_range(15) == 0) begin
            if ($urandom_range(1) == 0) begin
                q.push_back(noise_byte());
                q.push_back(CHAR_LF);
            end else begin
                q.push_back(CHAR_CR);
                q.push_back(noise_byte());
            end
        end else begin
            q.push_back(CHAR_CR);
            q.push_back(CHAR_LF);
        end
    endfunction

    function automatic void push_hex(ref byte_q_t q, input int unsigned value);
        byte_q_t     digits;
        int unsigned rest;
        logic [3:0]  nib;
        rest = value;
        do begin
            nib = rest[3:0];
            if (nib < 4'd10)
                digits.push_front(CHAR_ZERO + 8'(nib));
            else
                digits.push_front(($urandom_range(1) ? CHAR_LOW_A : CHAR_HIGH_A) + 8'(nib - 4'd10));
            rest = rest >> 4;
        end while (rest != 0);
        repeat ($urandom_range(2)) digits.push_front(CHAR_ZERO);
        foreach (digits[i]) q.push_back(digits[i]);
    endfunction

    // Ends the digits with a non-hex character and fills the rest of the size line,
    // sometimes with a carriage return that is not followed by a line feed.
    function automatic void push_line_tail(ref byte_q_t q);
        string stoppers;
        stoppers = " ;gGxXzZ";
        q.push_back(stoppers[$urandom_range(7)]);
        repeat ($urandom_range(4)) q.push_back(8'($urandom_range(8'h7E, 8'h20)));
        if ($urandom_range(2) == 0) begin
            q.push_back(CHAR_CR);
            q.push_back("q");
        end
    endfunction

    function automatic void build_response(ref byte_q_t q, input int unsigned forced_size);
        int unsigned size;
        int unsigned cut;
        q.delete();
        repeat ($urandom_range(6)) q.push_back(noise_byte());
        push_crlf(q, 1'b0);
        push_crlf(q, 1'b0);
        repeat ((forced_size != 0) ? 1 : $urandom_range(3)) begin
            if (forced_size != 0) size = forced_size;
            else if ($urandom_range(9) == 0) size = $urandom_range(48, 16);
            else size = $urandom_range(6, 1);
            push_hex(q, size);
            if ($urandom_range(3) == 0) push_line_tail(q);
            push_crlf(q, 1'b0);
            repeat (size) q.push_back(8'($urandom));
            push_crlf(q, forced_size == 0);
        end
        if ($urandom_range(3) != 0) repeat ($urandom_range(2, 1)) q.push_back(CHAR_ZERO);
        if ($urandom_range(3) == 0) push_line_tail(q);
        push_crlf(q, 1'b0);
        push_crlf(q, forced_size == 0);
        if (forced_size == 0) begin
            if ($urandom_range(7) == 0) begin
                cut = $urandom_range(q.size(), 1);
                while (q.size() > cut) void'(q.pop_back());
            end else if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(3, 1)) q.push_back(noise_byte());
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_buffer(ref byte_q_t q);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_random_until(input int target);
        byte_q_t q;
        while (bytes_sent < target) begin
            if ($urandom_range(9) == 0) begin
                q.delete();
                repeat ($urandom_range(12, 1)) q.push_back(noise_byte());
            end else begin
                build_response(q, 0);
            end
            send_buffer(q);
        end
    endtask

    initial begin
        byte_q_t q;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A two-byte chunk with both byte extremes, closed by a "0x" size line.
        q = {CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, "2", CHAR_CR, CHAR_LF, 8'h00, 8'hFF,
             CHAR_CR, CHAR_LF, "0", "x", CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};
        send_buffer(q);
        // Empty size line, a missing line end, then an ignored tail byte.
        q = {CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, "Z", 8'hFF};
        send_buffer(q);

        send_random_until(ITEMS_PER_PHASE);
        tx_idle_pct = 46;
        rx_idle_pct = 19;
        send_random_until(2 * ITEMS_PER_PHASE);
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        hold_request = 1'b1;
        build_response(q, 40);
        send_buffer(q);

        q = {CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};
        push_hex(q, 32'hFFFFFFFF);
        push_crlf(q, 1'b0);
        repeat (5) q.push_back(8'($urandom));
        send_buffer(q);

        send_random_until(3 * ITEMS_PER_PHASE);
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_http_chunked_decoder: PASS");
        end else begin
            $display("tb_http_chunked_decoder: FAIL");
        end
        $finish;
    end

endmodule
